// ----- hdl/sawdr_pkg.sv -----
// Shared types and constants for the stop-and-wait datagram receiver.
package sawdr_pkg;

	localparam int unsigned MAX_PACKET = 1500;
	localparam int unsigned HDR_LEN    = 10;
	localparam int unsigned POS_W      = 11;
	localparam int unsigned POS_MAX    = 2047;
	localparam int unsigned OUT_BITS   = 73;
	localparam int unsigned OUT_BYTES  = (OUT_BITS + 7) / 8;
	localparam int unsigned OUT_W      = OUT_BYTES * 8;

	localparam logic [7:0] FLAG_SYN = 8'd1;
	localparam logic [7:0] FLAG_FIN = 8'd2;

	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_CONN   = 2'd1,
		PH_CLOSED = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		RT_DATA = 2'd0,
		RT_SYN  = 2'd1,
		RT_FIN  = 2'd2
	} reply_type_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} beat_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        reply_valid;
		logic [15:0] reply_seq;
		logic [15:0] reply_ack;
		logic        reply_ack_flag;
		logic [1:0]  reply_type;
		logic [15:0] reply_checksum;
		logic        packet_good;
		logic        file_done;
		logic [7:0]  file_number;
		logic [1:0]  link_phase;
	} result_t;

endpackage

// ----- hdl/sawdr_in_stage.sv -----
// Input register for received datagram bytes.
module sawdr_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // rx_byte
	input  logic                 s_tlast,  // last_byte
	input  logic                 advance,
	output logic                 beat_valid,
	output sawdr_pkg::beat_t     beat
);

	logic             valid_s1;
	sawdr_pkg::beat_t beat_s1;

	assign s_tready   = !valid_s1 || advance;
	assign beat_valid = valid_s1;
	assign beat       = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1.rx_byte   <= s_tdata;
			beat_s1.last_byte <= s_tlast;
		end
	end

endmodule

// ----- hdl/sawdr_core.sv -----
// Link state, header capture, checksum and verdict logic for one byte.
module sawdr_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  sawdr_pkg::beat_t     beat,
	output logic                 res_emit,
	output sawdr_pkg::result_t   res
);

	sawdr_pkg::phase_t           phase_q, phase_n;
	logic [sawdr_pkg::POS_W-1:0] pos_q, pos_n;
	logic [15:0]                 sum_q, sum_n;
	logic [7:0]                  hold_q, hold_n;
	logic                        pend_q, pend_n;
	logic [15:0]                 seq_q, seq_n;
	logic [15:0]                 ack_q, ack_n;
	logic [7:0]                  flag_q, flag_n;
	logic [15:0]                 len_q, len_n;
	logic [15:0]                 exp_q, exp_n;
	logic [7:0]                  files_q, files_n;

	logic [16:0] limit;
	logic [16:0] pos_wide;
	logic [16:0] pay_end;
	logic        active;
	logic        data_mode;
	logic        take;
	logic        pay;
	logic [15:0] sum_a;
	logic        pend_a;
	logic [7:0]  hold_a;
	logic [15:0] sum_f;
	logic [15:0] checks;
	logic        good;
	logic        below_max;

	function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] w);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, w};
		return t[16] ? (t[15:0] + 16'd1) : t[15:0];
	endfunction

	always_comb begin
		active = phase_q != sawdr_pkg::PH_CLOSED;
		seq_n  = seq_q;
		ack_n  = ack_q;
		flag_n = flag_q;
		len_n  = len_q;
		if (active) begin
			case (pos_q)
				11'd0:   seq_n[15:8] = beat.rx_byte;
				11'd1:   seq_n[7:0]  = beat.rx_byte;
				11'd2:   ack_n[15:8] = beat.rx_byte;
				11'd3:   ack_n[7:0]  = beat.rx_byte;
				11'd5:   flag_n      = beat.rx_byte;
				11'd6:   len_n[15:8] = beat.rx_byte;
				11'd7:   len_n[7:0]  = beat.rx_byte;
				default: ;
			endcase
		end

		data_mode = phase_q == sawdr_pkg::PH_CONN && flag_n != sawdr_pkg::FLAG_SYN &&
			flag_n != sawdr_pkg::FLAG_FIN && seq_n == exp_q;
		pos_wide  = {{(17 - sawdr_pkg::POS_W){1'b0}}, pos_q};
		pay_end   = 17'(sawdr_pkg::HDR_LEN) + {1'b0, len_n};
		limit     = (phase_q == sawdr_pkg::PH_WAIT || flag_n == sawdr_pkg::FLAG_FIN) ?
			17'(sawdr_pkg::HDR_LEN) : pay_end;
		below_max = pos_q < sawdr_pkg::POS_W'(sawdr_pkg::MAX_PACKET);
		take      = active && pos_wide < limit && below_max;
		pay       = active && data_mode && pos_q >= sawdr_pkg::POS_W'(sawdr_pkg::HDR_LEN) &&
			pos_wide < pay_end && below_max;

		// pair the held high byte with this one, or hold this one
		sum_a  = (take && pend_q) ? ones_add(sum_q, {hold_q, beat.rx_byte}) : sum_q;
		pend_a = take ? !pend_q : pend_q;
		hold_a = (take && !pend_q) ? beat.rx_byte : hold_q;

		// odd final byte: pad with a zero low byte
		sum_f  = pend_a ? ones_add(sum_a, {hold_a, 8'h00}) : sum_a;
		checks = ~sum_f;
		good   = checks == 16'd0;
	end

	always_comb begin
		phase_n = phase_q;
		exp_n   = exp_q;
		files_n = files_q;
		pos_n   = (pos_q == sawdr_pkg::POS_W'(sawdr_pkg::POS_MAX)) ? pos_q :
			pos_q + sawdr_pkg::POS_W'(1);
		sum_n   = sum_a;
		pend_n  = pend_a;
		hold_n  = hold_a;

		res                = '0;
		res.payload_valid  = pay;
		res.payload_byte   = pay ? beat.rx_byte : 8'd0;
		res_emit           = pay || beat.last_byte;

		if (beat.last_byte) begin
			case (phase_q)
				sawdr_pkg::PH_WAIT: begin
					if (flag_n == sawdr_pkg::FLAG_SYN && good) begin
						res.reply_valid    = 1'b1;
						res.reply_seq      = seq_n;
						res.reply_ack      = seq_n + 16'd1;
						res.reply_ack_flag = 1'b1;
						res.reply_type     = sawdr_pkg::RT_SYN;
						res.reply_checksum = checks;
						phase_n            = sawdr_pkg::PH_CONN;
						exp_n              = 16'd0;
					end else begin
						phase_n = sawdr_pkg::PH_CLOSED;
					end
				end
				sawdr_pkg::PH_CONN: begin
					if (flag_n == sawdr_pkg::FLAG_FIN) begin
						if (good) begin
							res.reply_valid    = 1'b1;
							res.reply_seq      = seq_n;
							res.reply_ack      = seq_n + 16'd1;
							res.reply_ack_flag = 1'b1;
							res.reply_type     = sawdr_pkg::RT_FIN;
							res.reply_checksum = checks;
						end
						phase_n = sawdr_pkg::PH_CLOSED;
					end else if (data_mode) begin
						res.reply_valid    = 1'b1;
						res.reply_seq      = seq_n;
						res.reply_ack      = ack_n;
						res.reply_ack_flag = good;
						res.reply_type     = sawdr_pkg::RT_DATA;
						res.reply_checksum = checks;
						if (good) begin
							res.packet_good = 1'b1;
							exp_n           = seq_n + 16'd1;
							if (ack_n == 16'd0) begin
								res.file_done = 1'b1;
								files_n       = files_q + 8'd1;
								exp_n         = 16'd0;
							end
						end
					end
				end
				default: ;
			endcase
			// drop the per-datagram state
			pos_n  = '0;
			sum_n  = '0;
			pend_n = 1'b0;
			hold_n = '0;
		end

		res.file_number = files_n;
		res.link_phase  = phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sawdr_pkg::PH_WAIT;
			pos_q   <= '0;
			sum_q   <= '0;
			hold_q  <= '0;
			pend_q  <= 1'b0;
			seq_q   <= '0;
			ack_q   <= '0;
			flag_q  <= '0;
			len_q   <= '0;
			exp_q   <= '0;
			files_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			sum_q   <= sum_n;
			hold_q  <= hold_n;
			pend_q  <= pend_n;
			seq_q   <= beat.last_byte ? 16'd0 : seq_n;
			ack_q   <= beat.last_byte ? 16'd0 : ack_n;
			flag_q  <= beat.last_byte ? 8'd0 : flag_n;
			len_q   <= beat.last_byte ? 16'd0 : len_n;
			exp_q   <= exp_n;
			files_q <= files_n;
		end
	end

endmodule

// ----- hdl/sawdr_out_stage.sv -----
// Result register and beat packing for the master side.
module sawdr_out_stage (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  sawdr_pkg::result_t               res,
	output logic                             slot_free,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sawdr_pkg::OUT_W-1:0]      m_tdata
);

	logic               valid_q;
	sawdr_pkg::result_t res_q;

	assign slot_free = !valid_q || m_tready;
	assign m_tvalid  = valid_q;

	assign m_tdata = {
		{(sawdr_pkg::OUT_W - sawdr_pkg::OUT_BITS){1'b0}},
		res_q.link_phase,
		res_q.file_number,
		res_q.file_done,
		res_q.packet_good,
		res_q.reply_checksum,
		res_q.reply_type,
		res_q.reply_ack_flag,
		res_q.reply_ack,
		res_q.reply_seq,
		res_q.reply_valid,
		res_q.payload_byte,
		res_q.payload_valid
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && slot_free) begin
			res_q <= res;
		end
	end

endmodule

// ----- hdl/stop_and_wait_datagram_receiver.sv -----
// Stop-and-wait datagram receiver: top level.
// A result beat reaches m_* through the input register, then the result register,
// once its byte is accepted.
// Throughput: one byte per cycle; the result register stalls the input only
// while a result is held and m_tready is low.
// Reset (arst_n low) clears the link to awaiting SYN, counters and sums to zero.
module stop_and_wait_datagram_receiver (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [7:0] rx_byte
	input  logic                             s_tlast,  // last_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] payload_valid, [8:1] payload_byte, [9] reply_valid, [25:10] reply_seq,
	// [41:26] reply_ack, [42] reply_ack_flag, [44:43] reply_type,
	// [60:45] reply_checksum, [61] packet_good, [62] file_done,
	// [70:63] file_number, [72:71] link_phase, [79:73] zero
	output logic [sawdr_pkg::OUT_W-1:0]      m_tdata
);

	logic               beat_valid;
	sawdr_pkg::beat_t   beat;
	logic               slot_free;
	logic               advance;
	logic               res_emit;
	sawdr_pkg::result_t res;

	// advance a byte only when its result, if any, has somewhere to go
	assign advance = beat_valid && slot_free;

	sawdr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.advance    (advance),
		.beat_valid (beat_valid),
		.beat       (beat)
	);

	sawdr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.beat     (beat),
		.res_emit (res_emit),
		.res      (res)
	);

	sawdr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_emit),
		.res       (res),
		.slot_free (slot_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
